@@ hdl/alvr_pkg.sv @@
// Shared types and constants for the acceleration-limited velocity ramp.
`default_nettype none

package alvr_pkg;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_APPLY,
    ST_FINISH
  } state_t;

  // Input item kinds, carried in tuser
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_MAX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_MIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DUMMY    = 3'd5;

  // Axis selection: x, y, theta
  localparam logic [1:0] AXIS_FIRST = 2'd0;
  localparam logic [1:0] AXIS_LAST  = 2'd2;

  localparam int unsigned DEADBAND_W     = 12;
  localparam int unsigned DEADBAND_RESET = 4;
  localparam int unsigned TIMEOUT_RESET  = 100;
  localparam int unsigned TICKS_RESET    = 100;
  localparam int unsigned PACK_LIMIT     = 64;

  typedef struct packed {
    logic       load;
    logic       tick_start;
    logic       div_start;
    logic       apply;
    logic       out_load;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic dummy;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

@@ hdl/alvr_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
`default_nettype none

module alvr_div #(
  parameter int unsigned NUM_W = 16,
  parameter int unsigned DEN_W = 17
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo,
  output logic                  done
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem, num_sh[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      rem    <= '0;
      den_r  <= den;
      quo    <= '0;
    end else if (cnt != '0) begin
      num_sh <= num_sh << 1;
      rem    <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo    <= {quo[NUM_W-2:0], fits};
    end
  end

  assign done = (cnt == '0);

endmodule

`default_nettype wire

@@ hdl/alvr_datapath.sv @@
// Datapath: configuration, axis state, countdown, shared divider and result register.
`default_nettype none

module alvr_datapath #(
  parameter int unsigned VEL_WIDTH  = 16,
  parameter int unsigned TICK_WIDTH = 16,
  parameter int unsigned CFG_W      = 48
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire alvr_pkg::cmd_t                          cmd,
  output alvr_pkg::status_t                            stat,
  input  wire logic                                    cfg_wr_en,
  input  wire logic [alvr_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]                        cfg_data,
  input  wire logic signed [VEL_WIDTH-1:0]             in_target_x,
  input  wire logic signed [VEL_WIDTH-1:0]             in_target_y,
  input  wire logic signed [VEL_WIDTH-1:0]             in_target_theta,
  input  wire logic [TICK_WIDTH-1:0]                   in_due_ticks,
  output logic signed [VEL_WIDTH-1:0]                  out_vel_x,
  output logic signed [VEL_WIDTH-1:0]                  out_vel_y,
  output logic signed [VEL_WIDTH-1:0]                  out_vel_theta,
  output logic signed [VEL_WIDTH-1:0]                  out_target_x,
  output logic signed [VEL_WIDTH-1:0]                  out_target_y,
  output logic signed [VEL_WIDTH-1:0]                  out_target_theta,
  output logic                                         out_cmd_valid,
  output logic                                         out_stale
);

  localparam int unsigned VW     = VEL_WIDTH;
  localparam int unsigned TW     = TICK_WIDTH;
  localparam int unsigned PW     = 3 * VW;
  localparam int unsigned PACK_W = (PW > alvr_pkg::PACK_LIMIT) ? alvr_pkg::PACK_LIMIT : PW;
  localparam int unsigned RW     = TW + 1;
  localparam int unsigned CNTW   = TW + 2;
  localparam int unsigned DBW    = (VW > alvr_pkg::DEADBAND_W) ? VW : alvr_pkg::DEADBAND_W;
  localparam logic [PW-1:0]   PACK_MASK = ~({PW{1'b1}} << PACK_W);
  localparam logic [CNTW-1:0] CNT_MIN   = {1'b1, {(CNTW-1){1'b0}}};

  // Configuration
  logic [PW-1:0]                     vel_max;
  logic [PW-1:0]                     vel_min;
  logic [PW-1:0]                     acc_step;
  logic [TW-1:0]                     timeout_ticks;
  logic [alvr_pkg::DEADBAND_W-1:0]   deadband;
  logic                              hold_mode;

  // Axis state
  logic signed [VW-1:0]   vel [3];
  logic signed [VW-1:0]   tgt [3];
  logic signed [CNTW-1:0] ticks;
  logic [RW-1:0]          r_div;
  logic                   stale_r;
  logic                   valid_r;
  logic                   err_neg;

  logic signed [VW-1:0] hi [3];
  logic signed [VW-1:0] lo [3];
  logic signed [VW-1:0] acc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hi[i]  = vel_max[i*VW +: VW];
      lo[i]  = vel_min[i*VW +: VW];
      acc[i] = acc_step[i*VW +: VW];
    end
  end

  function automatic logic signed [VW-1:0] clip(input logic signed [VW+1:0] v,
                                                input logic signed [VW-1:0] up,
                                                input logic signed [VW-1:0] dn);
    logic signed [VW+1:0] up_x;
    logic signed [VW+1:0] dn_x;
    up_x = (VW+2)'(up);
    dn_x = (VW+2)'(dn);
    if (v > up_x) begin
      return up;
    end else if (v < dn_x) begin
      return dn;
    end
    return v[VW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vel_max       <= '0;
      vel_min       <= '0;
      acc_step      <= '0;
      timeout_ticks <= TW'(alvr_pkg::TIMEOUT_RESET);
      deadband      <= alvr_pkg::DEADBAND_W'(alvr_pkg::DEADBAND_RESET);
      hold_mode     <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        alvr_pkg::REG_VEL_MAX:  vel_max       <= cfg_data[PW-1:0] & PACK_MASK;
        alvr_pkg::REG_VEL_MIN:  vel_min       <= cfg_data[PW-1:0] & PACK_MASK;
        alvr_pkg::REG_ACC_STEP: acc_step      <= cfg_data[PW-1:0] & PACK_MASK;
        alvr_pkg::REG_TIMEOUT:  timeout_ticks <= cfg_data[TW-1:0];
        alvr_pkg::REG_DEADBAND: deadband      <= cfg_data[alvr_pkg::DEADBAND_W-1:0];
        alvr_pkg::REG_DUMMY:    hold_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Tick entry: remaining ticks, timeout check
  logic                 ticks_pos;
  logic [CNTW-1:0]      ticks_mag;
  logic                 timed_out;

  assign ticks_pos = !ticks[CNTW-1] && (ticks != '0);
  assign ticks_mag = CNTW'(-ticks);
  assign timed_out = ticks[CNTW-1] && (ticks_mag > CNTW'(timeout_ticks));

  // Divider operand for the selected axis
  logic signed [VW:0] err;
  logic [VW:0]        err_abs;

  assign err     = (VW+1)'(tgt[cmd.axis]) - (VW+1)'(vel[cmd.axis]);
  assign err_abs = err[VW] ? (VW+1)'(-err) : err;

  logic [VW-1:0] quo;
  logic          div_done;

  alvr_div #(
    .NUM_W (VW),
    .DEN_W (RW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (err_abs[VW-1:0]),
    .den   (r_div),
    .quo   (quo),
    .done  (div_done)
  );

  // Step limit, integrate, clip, deadband
  logic [VW-1:0]        acc_mag;
  logic [VW-1:0]        step_mag;
  logic signed [VW+1:0] step;
  logic signed [VW+1:0] sum;
  logic signed [VW-1:0] clipped;
  logic [VW-1:0]        clipped_abs;
  logic signed [VW-1:0] vel_new;

  always_comb begin
    acc_mag     = acc[cmd.axis][VW-1] ? '0 : acc[cmd.axis];
    step_mag    = (quo > acc_mag) ? acc_mag : quo;
    step        = err_neg ? -(VW+2)'(step_mag) : (VW+2)'(step_mag);
    sum         = (VW+2)'(vel[cmd.axis]) + step;
    clipped     = clip(sum, hi[cmd.axis], lo[cmd.axis]);
    clipped_abs = clipped[VW-1] ? VW'(-clipped) : clipped;
    vel_new     = (DBW'(clipped_abs) < DBW'(deadband)) ? '0 : clipped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        vel[i] <= '0;
        tgt[i] <= '0;
      end
      ticks <= CNTW'(alvr_pkg::TICKS_RESET);
    end else begin
      if (cmd.load) begin
        tgt[0] <= clip((VW+2)'(in_target_x), hi[0], lo[0]);
        tgt[1] <= clip((VW+2)'(in_target_y), hi[1], lo[1]);
        tgt[2] <= clip((VW+2)'(in_target_theta), hi[2], lo[2]);
        ticks  <= CNTW'(in_due_ticks);
      end
      if (cmd.tick_start) begin
        if (!hold_mode && timed_out) begin
          for (int i = 0; i < 3; i++) begin
            tgt[i] <= '0;
          end
        end
        // saturate the countdown at its floor
        if (ticks != CNT_MIN) begin
          ticks <= ticks - 1'b1;
        end
      end
      if (cmd.apply) begin
        vel[cmd.axis] <= vel_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      r_div   <= ticks_pos ? ticks[RW-1:0] : RW'(1);
      stale_r <= !hold_mode && timed_out;
      valid_r <= !hold_mode;
    end
    if (cmd.div_start) begin
      err_neg <= err[VW];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_vel_x        <= vel[0];
      out_vel_y        <= vel[1];
      out_vel_theta    <= vel[2];
      out_target_x     <= tgt[0];
      out_target_y     <= tgt[1];
      out_target_theta <= tgt[2];
      out_cmd_valid    <= valid_r;
      out_stale        <= stale_r;
    end
  end

  assign stat = '{dummy: hold_mode, div_done: div_done};

endmodule

`default_nettype wire

@@ hdl/alvr_ctrl.sv @@
// Controller: sequences load, per-axis divide and update, and result handover.
`default_nettype none

module alvr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_mode,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output alvr_pkg::cmd_t         cmd,
  input  wire alvr_pkg::status_t stat
);

  alvr_pkg::state_t state;
  alvr_pkg::state_t state_next;
  logic [1:0]       axis;
  logic             accept;
  logic             out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      alvr_pkg::ST_IDLE: begin
        if (accept && in_mode == alvr_pkg::MODE_TICK) begin
          state_next = stat.dummy ? alvr_pkg::ST_FINISH : alvr_pkg::ST_DIV_START;
        end
      end
      alvr_pkg::ST_DIV_START: state_next = alvr_pkg::ST_DIV_WAIT;
      alvr_pkg::ST_DIV_WAIT: begin
        if (stat.div_done) begin
          state_next = alvr_pkg::ST_APPLY;
        end
      end
      alvr_pkg::ST_APPLY: begin
        state_next = (axis == alvr_pkg::AXIS_LAST) ? alvr_pkg::ST_FINISH
                                                   : alvr_pkg::ST_DIV_START;
      end
      alvr_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = alvr_pkg::ST_IDLE;
        end
      end
      default: state_next = alvr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state == alvr_pkg::ST_IDLE);
    cmd.load       = accept && in_mode == alvr_pkg::MODE_LOAD;
    cmd.tick_start = accept && in_mode == alvr_pkg::MODE_TICK;
    cmd.div_start  = (state == alvr_pkg::ST_DIV_START);
    cmd.apply      = (state == alvr_pkg::ST_APPLY);
    cmd.out_load   = (state == alvr_pkg::ST_FINISH) && out_free;
    cmd.axis       = axis;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= alvr_pkg::ST_IDLE;
      axis      <= alvr_pkg::AXIS_FIRST;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == alvr_pkg::ST_IDLE) begin
        axis <= alvr_pkg::AXIS_FIRST;
      end else if (state == alvr_pkg::ST_APPLY) begin
        axis <= axis + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before its beat was taken");

  a_last_axis_finish: assert property (@(posedge clk) disable iff (rst)
    (state == alvr_pkg::ST_APPLY && axis == alvr_pkg::AXIS_LAST)
      |=> state == alvr_pkg::ST_FINISH)
    else $error("tick did not finish after the last axis");

  a_dummy_skip: assert property (@(posedge clk) disable iff (rst)
    (cmd.tick_start && stat.dummy) |=> state == alvr_pkg::ST_FINISH)
    else $error("dummy tick entered the divide sequence");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == alvr_pkg::ST_FINISH)
    else $error("result raised outside the finish step");
`endif

endmodule

`default_nettype wire

@@ hdl/accel_limited_velocity_ramp_top.sv @@
// Top level: stream ports, configuration port, controller and datapath.
`default_nettype none

// Three-axis velocity slew limiter (x, y, theta), signed Q4.12. A load beat
// (tuser = 1) clips a new target to the velocity limits and sets the due
// countdown; it yields no output beat. A tick beat (tuser = 0) moves each
// axis toward its target by error / remaining ticks, limited to the per-tick
// acceleration step, then clips and applies the deadband, and yields one
// output beat. Each tick runs the three axes in turn through the single
// restoring divider they share, one quotient bit per cycle, and the next beat
// is taken only once the result is registered; in dummy mode the tick skips
// the divider. The result sits in an output register, so the next beat is
// accepted while it waits to be taken; a tick that finishes while that
// register is still full holds until it is taken.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data; the user
// must write it only while idle, as the block does not enforce this.

module accel_limited_velocity_ramp_top #(
  parameter int unsigned VEL_WIDTH  = 16,
  parameter int unsigned TICK_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // target_x, target_y, target_theta, due_ticks, zero padding
  input  wire logic [((3*VEL_WIDTH+TICK_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // mode
  input  wire logic                                s_axis_tuser,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // vel_x, vel_y, vel_theta, cur_target_x, cur_target_y, cur_target_theta, zero padding
  output logic [((6*VEL_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
  // cmd_valid, stale
  output logic [1:0]                               m_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic                                cfg_wr_en,
  input  wire logic [alvr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [((3*VEL_WIDTH > TICK_WIDTH) ? 3*VEL_WIDTH : TICK_WIDTH)-1:0] cfg_data
);

  localparam int unsigned VW     = VEL_WIDTH;
  localparam int unsigned TW     = TICK_WIDTH;
  localparam int unsigned OUT_DW = ((6*VW+7)/8)*8;
  localparam int unsigned CFG_W  = (3*VW > TW) ? 3*VW : TW;

  alvr_pkg::cmd_t    cmd;
  alvr_pkg::status_t stat;

  logic signed [VW-1:0] vel_x;
  logic signed [VW-1:0] vel_y;
  logic signed [VW-1:0] vel_theta;
  logic signed [VW-1:0] cur_target_x;
  logic signed [VW-1:0] cur_target_y;
  logic signed [VW-1:0] cur_target_theta;
  logic                 cmd_valid;
  logic                 stale;

  alvr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  alvr_datapath #(
    .VEL_WIDTH  (VW),
    .TICK_WIDTH (TW),
    .CFG_W      (CFG_W)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_target_x      (s_axis_tdata[0 +: VW]),
    .in_target_y      (s_axis_tdata[VW +: VW]),
    .in_target_theta  (s_axis_tdata[2*VW +: VW]),
    .in_due_ticks     (s_axis_tdata[3*VW +: TW]),
    .out_vel_x        (vel_x),
    .out_vel_y        (vel_y),
    .out_vel_theta    (vel_theta),
    .out_target_x     (cur_target_x),
    .out_target_y     (cur_target_y),
    .out_target_theta (cur_target_theta),
    .out_cmd_valid    (cmd_valid),
    .out_stale        (stale)
  );

  assign m_axis_tdata = OUT_DW'({cur_target_theta, cur_target_y, cur_target_x,
                                 vel_theta, vel_y, vel_x});
  assign m_axis_tuser = {stale, cmd_valid};

endmodule

`default_nettype wire

@@ verif/accel_limited_velocity_ramp_top_tb.sv @@
// Self-checking testbench for the acceleration-limited velocity ramp top level.
`timescale 1ns / 1ps

module accel_limited_velocity_ramp_top_tb;

  localparam int     SETTLE_CYCLES  = 64;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam longint DUE_FLOOR      = -(longint'(1) << 17);

  typedef struct packed {
    logic             stale;
    logic             cmd_valid;
    logic [2:0][15:0] tgt;
    logic [2:0][15:0] vel;
  } ramp_out_t;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        mode;
    logic [63:0] beat;
    logic [2:0]  reg_idx;
    logic [47:0] reg_val;
    bit          typed;
    ramp_out_t   want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  accel_limited_velocity_ramp_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state and its copy of the registers
  logic signed [15:0] vel_now [3] = '{0, 0, 0};
  logic signed [15:0] tgt_now [3] = '{0, 0, 0};
  longint             due_cnt     = 100;
  logic [47:0]        lim_hi      = '0;
  logic [47:0]        lim_lo      = '0;
  logic [47:0]        acc_lim     = '0;
  logic [15:0]        timeout_lim = 16'd100;
  logic [11:0]        dead_lim    = 12'd4;
  logic               dummy_on    = 1'b0;

  ramp_out_t pending_cmds [$];
  plan_row_t plan [$];
  string     axis_name [3] = '{"x", "y", "theta"};

  int snd_idle = 0;
  int rcv_idle = 0;
  int n_fail = 0;
  int n_loads = 0;
  int n_ticks = 0;
  int n_stale = 0;
  int n_held = 0;
  int n_writes = 0;
  int idle_run = 0;
  ramp_out_t want_cmd, seen_cmd;

  function automatic longint axis_slice(logic [47:0] packed_val, int k);
    return longint'($signed(packed_val[k*16 +: 16]));
  endfunction

  function automatic longint clip_axis(longint v, int k);
    longint hi, lo;
    hi = axis_slice(lim_hi, k);
    lo = axis_slice(lim_lo, k);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Returns 1 when the beat yields a command, with that command in cmd
  function automatic bit ramp_predict(input logic mode, input logic [63:0] beat,
                                      output ramp_out_t cmd);
    longint r, a, s, v;
    bit     stale_now;
    int     k;
    cmd = '0;
    stale_now = 1'b0;
    if (mode == alvr_pkg::MODE_LOAD) begin
      for (k = 0; k < 3; k++)
        tgt_now[k] = 16'(clip_axis(longint'($signed(beat[k*16 +: 16])), k));
      due_cnt = longint'(beat[63:48]);
      return 1'b0;
    end
    if (!dummy_on) begin
      r = (due_cnt > 0) ? due_cnt : 1;
      if (due_cnt < 0 && -due_cnt > longint'(timeout_lim)) begin
        stale_now = 1'b1;
        for (k = 0; k < 3; k++) tgt_now[k] = '0;
      end
      for (k = 0; k < 3; k++) begin
        a = axis_slice(acc_lim, k);
        if (a < 0) a = 0;
        s = (longint'(tgt_now[k]) - longint'(vel_now[k])) / r;
        if (s > a) s = a;
        if (s < -a) s = -a;
        v = clip_axis(longint'(vel_now[k]) + s, k);
        if (((v < 0) ? -v : v) < longint'(dead_lim)) v = 0;
        vel_now[k] = 16'(v);
      end
    end else begin
      n_held++;
    end
    // Countdown saturates at its floor
    if (due_cnt > DUE_FLOOR) due_cnt--;
    for (k = 0; k < 3; k++) begin
      cmd.vel[k] = vel_now[k];
      cmd.tgt[k] = tgt_now[k];
    end
    cmd.cmd_valid = !dummy_on;
    cmd.stale = stale_now;
    if (stale_now) n_stale++;
    return 1'b1;
  endfunction

  function automatic ramp_out_t cmd_of(logic [15:0] vx, vy, vth, tx, ty, tth,
                                       logic cv, st);
    return ramp_out_t'({st, cv, tth, ty, tx, vth, vy, vx});
  endfunction

  function automatic plan_row_t beat_row(logic mode, logic [15:0] x, y, th, due);
    plan_row_t row;
    row = '{ROW_BEAT, mode, {due, th, y, x}, '0, '0, 1'b0, '0};
    return row;
  endfunction

  function automatic plan_row_t typed_tick(ramp_out_t want);
    plan_row_t row;
    row = '{ROW_BEAT, alvr_pkg::MODE_TICK, '1, '0, '0, 1'b1, want};
    return row;
  endfunction

  function automatic plan_row_t write_row(logic [2:0] idx, logic [47:0] val);
    plan_row_t row;
    row = '{ROW_WRITE, alvr_pkg::MODE_TICK, '0, idx, val, 1'b0, '0};
    return row;
  endfunction

  function automatic logic [15:0] rand_vel();
    case ($urandom_range(7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_due();
    case ($urandom_range(7))
      0:       return 16'($urandom);
      1:       return 16'd0;
      default: return 16'($urandom_range(1, 20));
    endcase
  endfunction

  // Receiver side: drop tready at random
  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= rcv_idle);

  // Check each output beat against the oldest expected command
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_cmds.size() == 0) begin
        $error("output beat with no command expected");
        n_fail++;
      end else begin
        want_cmd = pending_cmds.pop_front();
        seen_cmd = ramp_out_t'({m_axis_tuser[1], m_axis_tuser[0], m_axis_tdata});
        for (int k = 0; k < 3; k++) begin
          if (seen_cmd.vel[k] !== want_cmd.vel[k]) begin
            $error("vel_%s: expected %0d, got %0d", axis_name[k],
                   $signed(want_cmd.vel[k]), $signed(seen_cmd.vel[k]));
            n_fail++;
          end
          if (seen_cmd.tgt[k] !== want_cmd.tgt[k]) begin
            $error("cur_target_%s: expected %0d, got %0d", axis_name[k],
                   $signed(want_cmd.tgt[k]), $signed(seen_cmd.tgt[k]));
            n_fail++;
          end
        end
        if (seen_cmd.cmd_valid !== want_cmd.cmd_valid) begin
          $error("cmd_valid: expected %0b, got %0b", want_cmd.cmd_valid,
                 seen_cmd.cmd_valid);
          n_fail++;
        end
        if (seen_cmd.stale !== want_cmd.stale) begin
          $error("stale: expected %0b, got %0b", want_cmd.stale, seen_cmd.stale);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_cmd(input logic mode, input logic [63:0] beat, input bit typed,
                          input ramp_out_t want);
    ramp_out_t predicted;
    bit        has_cmd;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= beat;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    has_cmd = ramp_predict(mode, beat, predicted);
    if (mode == alvr_pkg::MODE_LOAD) n_loads++;
    else n_ticks++;
    if (has_cmd) pending_cmds.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    drain_results();
    // A load leaves no result behind, so allow for one still in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    n_writes++;
    case (idx)
      alvr_pkg::REG_VEL_MAX:  lim_hi = val;
      alvr_pkg::REG_VEL_MIN:  lim_lo = val;
      alvr_pkg::REG_ACC_STEP: acc_lim = val;
      alvr_pkg::REG_TIMEOUT:  timeout_lim = val[15:0];
      alvr_pkg::REG_DEADBAND: dead_lim = val[11:0];
      alvr_pkg::REG_DUMMY:    dummy_on = val[0];
      default: ;
    endcase
  endtask

  task automatic set_random_config();
    logic [47:0] hi, lo, acc;
    logic [15:0] tmo;
    logic [11:0] dband;
    int          k;
    for (k = 0; k < 3; k++) begin
      case ($urandom_range(5))
        0: begin
          hi[k*16 +: 16] = 16'h7fff;
          lo[k*16 +: 16] = 16'h8000;
        end
        // Anything goes, inverted limits included
        1: begin
          hi[k*16 +: 16] = 16'($urandom);
          lo[k*16 +: 16] = 16'($urandom);
        end
        2: begin
          hi[k*16 +: 16] = 16'($urandom_range(200));
          lo[k*16 +: 16] = 16'(-int'($urandom_range(200)));
        end
        default: begin
          hi[k*16 +: 16] = 16'($urandom_range(32767));
          lo[k*16 +: 16] = 16'(-int'($urandom_range(32768)));
        end
      endcase
      case ($urandom_range(5))
        0:       acc[k*16 +: 16] = 16'h7fff;
        1:       acc[k*16 +: 16] = 16'($urandom);
        2:       acc[k*16 +: 16] = 16'($urandom_range(16));
        default: acc[k*16 +: 16] = 16'($urandom_range(3000));
      endcase
    end
    case ($urandom_range(5))
      0:       tmo = 16'd0;
      1:       tmo = 16'hffff;
      2:       tmo = 16'($urandom);
      default: tmo = 16'($urandom_range(25));
    endcase
    case ($urandom_range(5))
      0:       dband = 12'hfff;
      1:       dband = 12'd0;
      2:       dband = 12'($urandom);
      default: dband = 12'($urandom_range(64));
    endcase
    write_reg(alvr_pkg::REG_VEL_MAX, hi);
    write_reg(alvr_pkg::REG_VEL_MIN, lo);
    write_reg(alvr_pkg::REG_ACC_STEP, acc);
    write_reg(alvr_pkg::REG_TIMEOUT, 48'(tmo));
    write_reg(alvr_pkg::REG_DEADBAND, 48'(dband));
    write_reg(alvr_pkg::REG_DUMMY, 48'($urandom_range(5) == 0));
  endtask

  // Mostly a load followed by a run of ticks; now and then a stray beat
  task automatic run_segment(input int n_items);
    int done, run_len;
    set_random_config();
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(49) == 0) drain_results();
      if ($urandom_range(9) == 0) begin
        send_cmd(1'($urandom), {$urandom, $urandom}, 1'b0, '0);
        done++;
      end else begin
        send_cmd(alvr_pkg::MODE_LOAD, {rand_due(), rand_vel(), rand_vel(), rand_vel()},
                 1'b0, '0);
        done++;
        run_len = $urandom_range(1, 40);
        repeat (run_len) send_cmd(alvr_pkg::MODE_TICK, {$urandom, $urandom}, 1'b0, '0);
        done += run_len;
      end
    end
  endtask

  initial begin
    // After reset the limits are zero, so every target clips to zero
    plan.push_back(typed_tick(cmd_of('0, '0, '0, '0, '0, '0, 1'b1, 1'b0)));
    plan.push_back(beat_row(alvr_pkg::MODE_LOAD, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff));
    plan.push_back(typed_tick(cmd_of('0, '0, '0, '0, '0, '0, 1'b1, 1'b0)));
    // Widest limits and steps, no timeout grace, no deadband
    plan.push_back(write_row(alvr_pkg::REG_VEL_MAX, {3{16'h7fff}}));
    plan.push_back(write_row(alvr_pkg::REG_VEL_MIN, {3{16'h8000}}));
    plan.push_back(write_row(alvr_pkg::REG_ACC_STEP, {3{16'h7fff}}));
    plan.push_back(write_row(alvr_pkg::REG_TIMEOUT, 48'd0));
    plan.push_back(write_row(alvr_pkg::REG_DEADBAND, 48'd0));
    plan.push_back(write_row(alvr_pkg::REG_DUMMY, 48'd0));
    plan.push_back(beat_row(alvr_pkg::MODE_LOAD, 16'h7fff, 16'h8000, 16'h0001, 16'd0));
    plan.push_back(typed_tick(cmd_of(16'h7fff, 16'h8001, 16'h0001,
                                     16'h7fff, 16'h8000, 16'h0001, 1'b1, 1'b0)));
    plan.push_back(typed_tick(cmd_of('0, '0, '0, '0, '0, '0, 1'b1, 1'b1)));
    // Widest deadband, longest timeout, negative step limit on theta
    plan.push_back(write_row(alvr_pkg::REG_DEADBAND, 48'hfff));
    plan.push_back(write_row(alvr_pkg::REG_TIMEOUT, 48'hffff));
    plan.push_back(write_row(alvr_pkg::REG_ACC_STEP, {16'h8000, 16'h7fff, 16'h0100}));
    plan.push_back(beat_row(alvr_pkg::MODE_LOAD, 16'd1000, 16'hec78, 16'd3000, 16'd3));
    repeat (2) plan.push_back(beat_row(alvr_pkg::MODE_TICK, 16'h0, 16'h0, 16'h0, 16'h0));
    plan.push_back(write_row(alvr_pkg::REG_DEADBAND, 48'd0));
    repeat (3)
      plan.push_back(beat_row(alvr_pkg::MODE_TICK, 16'hffff, 16'h0, 16'hffff, 16'h0));
    // Inverted limits on x, a narrow band on y
    plan.push_back(write_row(alvr_pkg::REG_VEL_MAX, {16'h7fff, 16'd50, 16'hff9c}));
    plan.push_back(write_row(alvr_pkg::REG_VEL_MIN, {16'h8000, 16'd40, 16'd100}));
    plan.push_back(beat_row(alvr_pkg::MODE_LOAD, 16'd7000, 16'h0, 16'h8000, 16'd2));
    repeat (2) plan.push_back(beat_row(alvr_pkg::MODE_TICK, 16'h0, 16'h0, 16'h0, 16'h0));
    // Dummy mode holds velocity but still counts down
    plan.push_back(write_row(alvr_pkg::REG_DUMMY, 48'd1));
    plan.push_back(beat_row(alvr_pkg::MODE_TICK, 16'h0, 16'h0, 16'h0, 16'h0));
    plan.push_back(beat_row(alvr_pkg::MODE_LOAD, 16'h0, 16'h0, 16'h0, 16'd5));
    plan.push_back(beat_row(alvr_pkg::MODE_TICK, 16'h0, 16'h0, 16'h0, 16'h0));
    plan.push_back(write_row(alvr_pkg::REG_DUMMY, 48'd0));
    plan.push_back(beat_row(alvr_pkg::MODE_TICK, 16'h0, 16'h0, 16'h0, 16'h0));

    snd_idle = 11;
    rcv_idle = 86;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE)
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      else
        send_cmd(plan[i].mode, plan[i].beat, plan[i].typed, plan[i].want);
    end

    repeat (5) run_segment(100);
    snd_idle = 86;
    rcv_idle = 11;
    repeat (5) run_segment(100);
    snd_idle = 0;
    rcv_idle = 0;
    repeat (5) run_segment(100);

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_cmds.size() != 0) begin
      $error("%0d expected commands never arrived", pending_cmds.size());
      n_fail++;
    end
    $display("Covered %0d loads and %0d ticks over %0d register writes,", n_loads,
             n_ticks, n_writes);
    $display("with %0d target timeouts and %0d ticks held in dummy mode.", n_stale,
             n_held);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
